// ===== rtl/ibm_pkg.sv =====
// Shared types and constants for the byte-level I2C master.
// Used by ibm_front, ibm_back and i2c_byte_master_top; depends on nothing.
package ibm_pkg;

  // Command opcodes, bits 9:8 of a command word.
  typedef enum logic [1:0] {
    OP_WRITE = 2'b00,
    OP_START = 2'b01,
    OP_STOP  = 2'b10,
    OP_READ  = 2'b11
  } ibm_op_e;

  localparam int unsigned CmdWidth  = 10;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned BitWidth  = 4;

  // Bits per command: data bits plus the acknowledge bit, or one bit time.
  localparam logic [BitWidth-1:0] BitsData    = 4'd9;
  localparam logic [BitWidth-1:0] BitsControl = 4'd1;
  localparam logic [BitWidth-1:0] DataBits    = 4'd8;

  // Classified input beat as it travels from the front to the back.
  typedef struct packed {
    logic                 is_cmd;
    ibm_op_e              op;
    logic [ByteWidth-1:0] data;
    logic                 nack;
    logic                 sda;
  } ibm_item_t;

  // One result beat.
  typedef struct packed {
    logic                 busy;
    logic                 nack_seen;
    logic [ByteWidth-1:0] read_byte;
    logic                 scl;
    logic                 sda;
  } ibm_result_t;

endpackage

// ===== rtl/i2c_byte_master_top.sv =====
// Top level of the byte-level I2C master with queue-style ports.
// Instantiates ibm_front and ibm_back; depends on ibm_pkg.

// Each input beat is either one clock tick of the bus timebase (mode 0) or a
// command word (mode 1), and every accepted beat yields exactly one result
// beat holding the busy flag, the NACK flag, the last byte read and the
// open-drain SCL/SDA releases. The block sustains one beat per cycle while
// the result side keeps popping: a pushed beat is decoded into a two-entry
// queue, taken from there by the phase sequencer once the two-entry result
// queue has room, and its result is registered into that queue, whose head
// is shown on the result ports until it is popped. Full rises only when
// the result side stalls and both queues fill. A command that arrives while
// a command is running is dropped. The divider register may be written only
// while no beat is in flight.
module i2c_byte_master_top #(
  parameter int unsigned DivBits      = 8,
  parameter int unsigned PhasesPerBit = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [DivBits-1:0]            cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          mode_i,
  input  logic [ibm_pkg::CmdWidth-1:0]  command_i,
  input  logic                          sda_in_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          busy_res_o,
  output logic                          nack_seen_o,
  output logic [ibm_pkg::ByteWidth-1:0] read_byte_o,
  output logic                          scl_release_o,
  output logic                          sda_release_o
);
  import ibm_pkg::*;

  logic        item_valid;
  logic        item_take;
  ibm_item_t   item;
  ibm_result_t result;

  // Decode and queue.
  ibm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .mode_i       (mode_i),
    .command_i    (command_i),
    .sda_in_i     (sda_in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // Sequencer and result queue.
  ibm_back #(
    .DivBits      (DivBits),
    .PhasesPerBit (PhasesPerBit)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result)
  );

  assign busy_res_o    = result.busy;
  assign nack_seen_o   = result.nack_seen;
  assign read_byte_o   = result.read_byte;
  assign scl_release_o = result.scl;
  assign sda_release_o = result.sda;

`ifndef SYNTHESIS
  // The back end never takes a beat from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |-> item_valid)
    else $error("back end took a beat from an empty queue");

  // An accepted input beat is waiting in the queue on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> item_valid)
    else $error("accepted beat missing from the queue");

  // SCL is only held low while a command is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !scl_release_o) |-> busy_res_o)
    else $error("SCL held low while idle");
`endif

endmodule

// ===== rtl/ibm_front.sv =====
// Front end of the I2C master: accepts input beats, decodes them and holds
// them in a two-entry queue for the back end. Depends on ibm_pkg.
module ibm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       mode_i,
  input  logic [ibm_pkg::CmdWidth-1:0] command_i,
  input  logic                       sda_in_i,
  output logic                       item_valid_o,
  output ibm_pkg::ibm_item_t         item_o,
  input  logic                       item_take_i
);
  import ibm_pkg::*;

  localparam int unsigned Depth = 2;

  ibm_item_t  queue_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;
  ibm_item_t  decoded;

  // Decode the beat: commands carry only the fields their opcode uses.
  always_comb begin
    decoded.is_cmd = mode_i;
    decoded.op     = ibm_op_e'(command_i[9:8]);
    decoded.data   = (decoded.op == OP_WRITE) ? command_i[7:0] : '0;
    decoded.nack   = (decoded.op == OP_READ) ? command_i[0] : 1'b0;
    decoded.sda    = sda_in_i;
  end

  assign full         = (count_q == 2'(Depth));
  assign do_push      = push && !full;
  assign do_pop       = item_take_i && (count_q != 2'd0);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = queue_q[rd_ptr_q];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= decoded;
    end
  end

endmodule

// ===== rtl/ibm_back.sv =====
// Back end of the I2C master: bit-phase sequencer driving SCL and SDA, plus
// a two-entry result queue. Depends on ibm_pkg.
module ibm_back #(
  parameter int unsigned DivBits     = 8,
  parameter int unsigned PhasesPerBit = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [DivBits-1:0]         cfg_wdata_i,
  input  logic                       item_valid_i,
  input  ibm_pkg::ibm_item_t         item_i,
  output logic                       item_take_o,
  output logic                       empty,
  input  logic                       pop,
  output ibm_pkg::ibm_result_t       result_o
);
  import ibm_pkg::*;

  localparam int unsigned PhW   = $clog2(PhasesPerBit);
  localparam int unsigned Depth = 2;
  localparam logic [PhW-1:0] PhChange = PhW'(PhasesPerBit / 6);
  localparam logic [PhW-1:0] PhHigh   = PhW'(PhasesPerBit / 2);
  localparam logic [PhW-1:0] PhSample = PhW'(PhasesPerBit / 2 + PhasesPerBit / 4);
  localparam logic [PhW:0]   PhCount  = (PhW + 1)'(PhasesPerBit);
  localparam logic [DivBits-1:0] DivReset = DivBits'(42);

  // Sequencer state.
  logic [DivBits-1:0]   div_q;
  logic [DivBits-1:0]   tick_q, tick_d;
  logic [PhW-1:0]       phase_q, phase_d;
  logic [BitWidth-1:0]  bit_q, bit_d;
  logic [ByteWidth-1:0] shift_q, shift_d;
  ibm_op_e              op_q, op_d;
  logic                 busy_q, busy_d;
  logic                 nack_q, nack_d;
  logic                 snack_q, snack_d;
  logic [ByteWidth-1:0] rbyte_q, rbyte_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;

  // Working values.
  logic [PhW:0]         ph_inc;
  logic [BitWidth-1:0]  bit_inc;
  logic [BitWidth-1:0]  bit_limit;
  logic                 finished;
  logic                 enter;

  // Result queue.
  ibm_result_t rq_q [Depth];
  logic        rwr_ptr_q;
  logic        rrd_ptr_q;
  logic [1:0]  rcount_q;
  logic        rpop;
  ibm_result_t res_d;

  // SDA level set at the change phase of a bit.
  function automatic logic change_level(ibm_op_e op, logic [BitWidth-1:0] b,
                                        logic [ByteWidth-1:0] sb, logic sn);
    logic lvl;
    lvl = 1'b0;
    unique case (op)
      OP_WRITE: lvl = (b < DataBits) ? sb[3'd7 - b[2:0]] : 1'b1;
      OP_READ:  lvl = (b < DataBits) ? 1'b1 : sn;
      OP_START: lvl = 1'b1;
      OP_STOP:  lvl = 1'b0;
      default:  lvl = 1'b0;
    endcase
    return lvl;
  endfunction

  assign item_take_o = item_valid_i && (rcount_q != 2'(Depth));
  assign bit_limit   = ((op_q == OP_WRITE) || (op_q == OP_READ)) ? BitsData : BitsControl;

  // Phase sequencer: one beat is a tick or a command.
  always_comb begin
    tick_d   = tick_q;
    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    op_d     = op_q;
    busy_d   = busy_q;
    nack_d   = nack_q;
    snack_d  = snack_q;
    rbyte_d  = rbyte_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ph_inc   = {1'b0, phase_q} + 1'b1;
    bit_inc  = bit_q + 1'b1;
    finished = 1'b0;
    enter    = 1'b0;
    if (item_take_o) begin
      if (item_i.is_cmd) begin
        // A command starts only when the sequencer is idle.
        if (!busy_q) begin
          op_d    = item_i.op;
          shift_d = item_i.data;
          snack_d = item_i.nack;
          tick_d  = '0;
          phase_d = '0;
          bit_d   = '0;
          busy_d  = 1'b1;
          scl_d   = 1'b0;
          if (PhChange == '0) begin
            sda_d = change_level(item_i.op, '0, item_i.data, item_i.nack);
          end
        end
      end else if (busy_q) begin
        if (({1'b0, tick_q} + 1'b1) < {1'b0, div_q}) begin
          tick_d = tick_q + 1'b1;
        end else begin
          tick_d = '0;
          if (ph_inc >= PhCount) begin
            phase_d = '0;
            if (bit_inc >= bit_limit) begin
              bit_d    = '0;
              busy_d   = 1'b0;
              finished = 1'b1;
              if (op_q == OP_READ) begin
                rbyte_d = shift_q;
              end
            end else begin
              bit_d = bit_inc;
            end
          end else begin
            phase_d = ph_inc[PhW-1:0];
          end
          enter = !finished;
        end
      end
    end

    // Actions on entering a new phase.
    if (enter) begin
      if (phase_d == '0) begin
        scl_d = 1'b0;
      end
      if (phase_d == PhChange) begin
        sda_d = change_level(op_q, bit_d, shift_q, snack_q);
      end
      if (phase_d == PhHigh) begin
        scl_d = 1'b1;
      end
      if (phase_d == PhSample) begin
        unique case (op_q)
          OP_WRITE: begin
            if (bit_d >= DataBits) begin
              nack_d = item_i.sda;
            end
          end
          OP_READ: begin
            if (bit_d < DataBits) begin
              shift_d = {shift_q[6:0], item_i.sda};
            end
          end
          OP_START: sda_d = 1'b0;
          default:  sda_d = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= DivReset;
      tick_q  <= '0;
      phase_q <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      op_q    <= OP_WRITE;
      busy_q  <= 1'b0;
      nack_q  <= 1'b0;
      snack_q <= 1'b0;
      rbyte_q <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        div_q <= cfg_wdata_i;
      end
      tick_q  <= tick_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      op_q    <= op_d;
      busy_q  <= busy_d;
      nack_q  <= nack_d;
      snack_q <= snack_d;
      rbyte_q <= rbyte_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  // Every taken beat yields one result beat with the updated state.
  always_comb begin
    res_d.busy      = busy_d;
    res_d.nack_seen = nack_d;
    res_d.read_byte = rbyte_d;
    res_d.scl       = scl_d;
    res_d.sda       = sda_d;
  end

  assign empty    = (rcount_q == 2'd0);
  assign rpop     = pop && !empty;
  assign result_o = rq_q[rrd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_ptr_q <= 1'b0;
      rrd_ptr_q <= 1'b0;
      rcount_q  <= 2'd0;
    end else begin
      if (item_take_o) begin
        rwr_ptr_q <= ~rwr_ptr_q;
      end
      if (rpop) begin
        rrd_ptr_q <= ~rrd_ptr_q;
      end
      rcount_q <= rcount_q + 2'(item_take_o) - 2'(rpop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      rq_q[rwr_ptr_q] <= res_d;
    end
  end

endmodule

// ===== dv/i2c_byte_master_top_tb.sv =====
// Self-checking testbench for the byte-level I2C master top level.
// Depends on ibm_pkg and i2c_byte_master_top; predicts every result beat
// from its own copy of the bus sequencer state and compares field by field.
`timescale 1ns / 100ps

module i2c_byte_master_top_tb;
  import ibm_pkg::*;

  localparam int PHASES     = 12;
  localparam int PH_CHANGE  = PHASES / 6;
  localparam int PH_HIGH    = PHASES / 2;
  localparam int PH_SAMPLE  = PHASES / 2 + PHASES / 4;
  localparam int DOG_LIMIT  = 2000;
  localparam int SETTLE     = 4;
  localparam int REPORT_MAX = 40;

  // One pending stimulus entry: either an input beat or a divider write.
  typedef struct {
    bit             is_cfg;
    logic [7:0]     div;
    logic           mode;
    logic [9:0]     cmd;
    logic           sda;
  } bus_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic       push = 1'b0;
  logic       full;
  logic       mode_i = 1'b0;
  logic [9:0] command_i = 10'd0;
  logic       sda_in_i = 1'b1;
  logic       empty;
  logic       pop = 1'b0;
  logic       busy_res_o;
  logic       nack_seen_o;
  logic [7:0] read_byte_o;
  logic       scl_release_o;
  logic       sda_release_o;

  i2c_byte_master_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .command_i     (command_i),
    .sda_in_i      (sda_in_i),
    .empty         (empty),
    .pop           (pop),
    .busy_res_o    (busy_res_o),
    .nack_seen_o   (nack_seen_o),
    .read_byte_o   (read_byte_o),
    .scl_release_o (scl_release_o),
    .sda_release_o (sda_release_o)
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bus_beat_t   pending_beats[$];
  ibm_result_t expected_states[$];
  int          errors = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  int          calm_left[2];
  int          push_wait = 0;
  int          pop_wait = 0;
  int          settle_cnt = 0;
  bit          beat_taken = 1'b0;
  bit          result_taken = 1'b0;

  // Predicted state of the bus sequencer, at reset values.
  logic [7:0] bus_div = 8'd42;
  logic [7:0] tick_cnt = 8'd0;
  logic [3:0] phase_no = 4'd0;
  logic [3:0] bit_no = 4'd0;
  logic [7:0] shift_reg = 8'd0;
  ibm_op_e    cur_op = OP_WRITE;
  logic       running = 1'b0;
  logic       nack_flag = 1'b0;
  logic       send_nack = 1'b0;
  logic [7:0] rx_byte = 8'd0;
  logic       scl_lvl = 1'b1;
  logic       sda_lvl = 1'b1;

  // Generator view: divider in use and ticks left until the command ends.
  int gen_div = 42;
  int gen_busy_left = 0;
  int gen_count = 0;

  function automatic logic [3:0] bit_times(ibm_op_e op);
    return (op == OP_WRITE || op == OP_READ) ? BitsData : BitsControl;
  endfunction

  // Line actions taken on entering a phase of the current bit time.
  task automatic enter_phase(input logic [3:0] ph, input logic sda_smp);
    if (ph == 0) scl_lvl = 1'b0;
    if (ph == PH_CHANGE) begin
      case (cur_op)
        OP_WRITE: sda_lvl = (bit_no < DataBits) ? shift_reg[7 - int'(bit_no)] : 1'b1;
        OP_READ:  sda_lvl = (bit_no < DataBits) ? 1'b1 : send_nack;
        OP_START: sda_lvl = 1'b1;
        default:  sda_lvl = 1'b0;
      endcase
    end
    if (ph == PH_HIGH) scl_lvl = 1'b1;
    if (ph == PH_SAMPLE) begin
      case (cur_op)
        OP_WRITE: if (bit_no >= DataBits) nack_flag = sda_smp;
        OP_READ:  if (bit_no < DataBits) shift_reg = {shift_reg[6:0], sda_smp};
        OP_START: sda_lvl = 1'b0;
        default:  sda_lvl = 1'b1;
      endcase
    end
  endtask

  // Applies one accepted beat to the predicted state and returns the line state.
  task automatic advance_bus(input logic mode, input logic [9:0] cmd, input logic sda_smp,
                             output ibm_result_t res);
    logic done;
    done = 1'b0;
    if (mode) begin
      // A command while a command runs is dropped.
      if (!running) begin
        cur_op    = ibm_op_e'(cmd[9:8]);
        shift_reg = (cur_op == OP_WRITE) ? cmd[7:0] : 8'd0;
        send_nack = (cur_op == OP_READ) ? cmd[0] : 1'b0;
        tick_cnt  = 8'd0;
        phase_no  = 4'd0;
        bit_no    = 4'd0;
        running   = 1'b1;
        enter_phase(4'd0, 1'b1);
      end
    end else if (running) begin
      if (int'(tick_cnt) + 1 < int'(bus_div)) begin
        tick_cnt = tick_cnt + 8'd1;
      end else begin
        tick_cnt = 8'd0;
        phase_no = phase_no + 4'd1;
        if (phase_no >= PHASES) begin
          phase_no = 4'd0;
          bit_no   = bit_no + 4'd1;
          if (bit_no >= bit_times(cur_op)) begin
            bit_no  = 4'd0;
            running = 1'b0;
            done    = 1'b1;
            if (cur_op == OP_READ) rx_byte = shift_reg;
          end
        end
        if (!done) enter_phase(phase_no, sda_smp);
      end
    end
    res.busy      = running;
    res.nack_seen = nack_flag;
    res.read_byte = rx_byte;
    res.scl       = scl_lvl;
    res.sda       = sda_lvl;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < REPORT_MAX)
      $display("%0t: result %0d %s: got %0h, expected %0h", $realtime, results_seen, what,
               got, want);
    errors++;
  endtask

  // Wait before the next beat: mostly a random draw, with calm stretches of none.
  function automatic int draw_gap(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left[side] = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Stimulus generation; tracks when the master would go idle again.
  task automatic add_beat(input logic mode, input logic [9:0] cmd, input logic sda);
    bus_beat_t b;
    int        eff;
    b.is_cfg = 1'b0;
    b.div    = 8'd0;
    b.mode   = mode;
    b.cmd    = cmd;
    b.sda    = sda;
    pending_beats.push_back(b);
    gen_count++;
    eff = (gen_div < 1) ? 1 : gen_div;
    if (mode) begin
      if (gen_busy_left == 0)
        gen_busy_left = PHASES * eff * int'(bit_times(ibm_op_e'(cmd[9:8])));
    end else if (gen_busy_left > 0) begin
      gen_busy_left--;
    end
  endtask

  task automatic set_divider(input int d);
    bus_beat_t b;
    b.is_cfg = 1'b1;
    b.div    = d[7:0];
    b.mode   = 1'b0;
    b.cmd    = 10'd0;
    b.sda    = 1'b0;
    pending_beats.push_back(b);
    gen_div = d;
  endtask

  task automatic finish_command();
    while (gen_busy_left > 0) add_beat(1'b0, 10'($urandom), 1'($urandom));
  endtask

  // Mostly whole commands with random content, plus idle ticks and noise.
  task automatic random_traffic(input int n);
    int         target;
    int         r;
    logic [9:0] cmd;
    target = gen_count + n;
    while (gen_count < target) begin
      if (gen_busy_left > 0) begin
        if ($urandom_range(0, 49) == 0) add_beat(1'b1, 10'($urandom), 1'($urandom));
        else add_beat(1'b0, 10'($urandom), 1'($urandom));
      end else begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          cmd = 10'($urandom);
          if ($urandom_range(0, 7) == 0) cmd[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          add_beat(1'b1, cmd, 1'($urandom));
        end else if (r < 9) begin
          add_beat(1'b0, 10'($urandom), 1'($urandom));
        end else begin
          repeat ($urandom_range(1, 4)) add_beat(1'($urandom), 10'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  // Input side: prediction on every accepted beat and on divider writes.
  always @(posedge clk_i) begin
    ibm_result_t res;
    if (rst_ni) begin
      if (cfg_we_i) bus_div = cfg_wdata_i;
      if (push && !full) begin
        advance_bus(mode_i, command_i, sda_in_i, res);
        expected_states.push_back(res);
        beat_taken = 1'b1;
      end
    end
  end

  // Driver: takes the next pending entry; divider writes wait for an idle block.
  always @(negedge clk_i) begin
    bus_beat_t b;
    logic      next_push;
    logic      next_we;
    if (rst_ni) begin
      next_push = push;
      next_we   = 1'b0;
      if (beat_taken) begin
        beat_taken = 1'b0;
        next_push  = 1'b0;
        push_wait  = draw_gap(0);
      end
      if (!next_push) begin
        if (push_wait > 0) begin
          push_wait--;
        end else if (pending_beats.size() > 0) begin
          b = pending_beats[0];
          if (b.is_cfg) begin
            if (expected_states.size() != 0) begin
              settle_cnt = 0;
            end else if (settle_cnt < SETTLE) begin
              settle_cnt++;
            end else begin
              settle_cnt = 0;
              next_we    = 1'b1;
              cfg_wdata_i <= b.div;
              void'(pending_beats.pop_front());
            end
          end else begin
            next_push = 1'b1;
            mode_i    <= b.mode;
            command_i <= b.cmd;
            sda_in_i  <= b.sda;
            void'(pending_beats.pop_front());
          end
        end
      end
      push     <= next_push;
      cfg_we_i <= next_we;
    end
  end

  // Monitor: compares each accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin
    ibm_result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        result_taken = 1'b1;
        if (expected_states.size() == 0) begin
          report_mismatch("unexpected beat, busy", busy_res_o, 0);
        end else begin
          want = expected_states.pop_front();
          if (busy_res_o !== want.busy) report_mismatch("busy", busy_res_o, want.busy);
          if (nack_seen_o !== want.nack_seen)
            report_mismatch("nack_seen", nack_seen_o, want.nack_seen);
          if (read_byte_o !== want.read_byte)
            report_mismatch("read_byte", read_byte_o, want.read_byte);
          if (scl_release_o !== want.scl) report_mismatch("scl", scl_release_o, want.scl);
          if (sda_release_o !== want.sda) report_mismatch("sda", sda_release_o, want.sda);
        end
        results_seen++;
      end
    end
  end

  // Result side stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) begin
        result_taken = 1'b0;
        pop_wait     = draw_gap(1);
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= DOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    // Reset divider: a STOP run to completion, then a tick while idle.
    add_beat(1'b1, {OP_STOP, 8'h00}, 1'b1);
    finish_command();
    add_beat(1'b0, 10'h3FF, 1'b0);

    // Directed part at the fastest divider: START, a command dropped while
    // busy, a tick while idle, STOP with its unused bits set, a write of all
    // ones and a read that ends with NACK.
    set_divider(1);
    add_beat(1'b1, {OP_START, 8'h00}, 1'b1);
    add_beat(1'b1, {OP_READ, 8'hFF}, 1'b0);
    for (int i = 0; i < PHASES; i++) add_beat(1'b0, 10'd0, i[0]);
    add_beat(1'b0, 10'd0, 1'b1);
    add_beat(1'b1, {OP_STOP, 8'hFF}, 1'b0);
    finish_command();
    add_beat(1'b1, {OP_WRITE, 8'hFF}, 1'b0);
    finish_command();
    add_beat(1'b1, {OP_READ, 8'h01}, 1'b1);
    finish_command();

    // Random phases over several dividers; the slowest one is left running.
    set_divider(2);
    random_traffic(200);
    finish_command();
    set_divider(1);
    random_traffic(150);
    finish_command();
    set_divider(3);
    random_traffic(150);
    finish_command();
    set_divider(255);
    random_traffic(150);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_beats.size() != 0 || push || expected_states.size() != 0);
    repeat (8) @(posedge clk_i);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ibm_pkg.sv
rtl/ibm_front.sv
rtl/ibm_back.sv
rtl/i2c_byte_master_top.sv
dv/i2c_byte_master_top_tb.sv
